/* sv/kabf_pkg.sv */
// kabf_pkg: shared constants and helper functions for the kalman angle/bias filter
// no dependencies

package kabf_pkg;

    localparam int CHANNELS = 3;
    localparam int CH_W = 2;
    localparam int FRAC = 24;

    localparam logic [30:0] RESET_Q_ANGLE = 31'd204682;
    localparam logic [30:0] RESET_Q_BIAS  = 31'd45298;
    localparam logic [30:0] RESET_R_MEAS  = 31'd167772;

    localparam logic [1:0] REG_Q_ANGLE = 2'd0;
    localparam logic [1:0] REG_Q_BIAS  = 2'd1;
    localparam logic [1:0] REG_R_MEAS  = 2'd2;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_SET    = 1'b1;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // round to nearest (ties up) then shift right by FRAC, floor
    function automatic logic signed [65:0] rnd24(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd8388608;
        return t >>> FRAC;
    endfunction

endpackage

/* sv/kalman_angle_bias_filter.sv */
// kalman_angle_bias_filter: per-axis two-state kalman filter (angle, gyro bias)
// an update item runs ten multiplies and two divides through one shared divider,
// plus the computation of s and a writeback; the divides are skipped when s <= 0;
// a set item and a bad channel are handled without multiplies or divides
// throughput: one item at a time, next accept the cycle after the result is taken
// reset: asynchronous active low, all channel state zero, noise registers
// to their defaults; depends on kabf_pkg, kabf_mul, kabf_div

module kalman_angle_bias_filter
    import kabf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // channel[1:0], measured_angle, gyro_rate, time_step[23:0]
    input  logic         s_tuser,   // action
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // filtered_angle, unbiased_rate
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_data
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b00000001,
        ST_MUL  = 8'b00000010,
        ST_MWT  = 8'b00000100,
        ST_DIV  = 8'b00001000,
        ST_DWT  = 8'b00010000,
        ST_CALC = 8'b00100000,
        ST_DONE = 8'b01000000,
        ST_OUT  = 8'b10000000
    } state_t;

    state_t state_reg;
    logic [3:0] step_reg;

    logic [30:0] qa_reg, qb_reg, r_reg;

    logic signed [31:0] ang_mem [CHANNELS];
    logic signed [31:0] bias_mem [CHANNELS];
    logic signed [31:0] p00_mem [CHANNELS];
    logic signed [31:0] p01_mem [CHANNELS];
    logic signed [31:0] p10_mem [CHANNELS];
    logic signed [31:0] p11_mem [CHANNELS];
    logic signed [31:0] rate_mem [CHANNELS];

    logic               act_reg;
    logic [CH_W-1:0]    ch_reg;
    logic signed [31:0] meas_reg;
    logic [23:0]        dt_reg;

    // working registers
    logic signed [31:0] rate_reg, ang_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [31:0] k0_reg, k1_reg, y_reg;
    logic signed [65:0] t_reg, inner_reg;
    logic [32:0]        s_reg;
    logic signed [31:0] oang_reg, orate_reg;
    logic               bad_ch;

    assign bad_ch = (32'(s_tdata[1:0]) >= CHANNELS);

    // multiplier operand select
    logic               mul_start, mul_done;
    logic signed [32:0] ma;
    logic signed [33:0] mb;
    logic signed [65:0] mrnd;
    logic signed [32:0] dt33;
    assign dt33 = $signed({9'd0, dt_reg});

    always_comb
    begin
        ma = dt33;
        mb = '0;
        case (step_reg)
            4'd0: mb = 34'(rate_reg);
            4'd1: mb = 34'(p11_reg);
            4'd2: mb = inner_reg[33:0];
            4'd3: mb = $signed({3'b0, qb_reg});
            4'd4: begin ma = 33'(k0_reg); mb = 34'(y_reg);   end
            4'd5: begin ma = 33'(k1_reg); mb = 34'(y_reg);   end
            4'd6: begin ma = 33'(k0_reg); mb = 34'(p00_reg); end
            4'd7: begin ma = 33'(k0_reg); mb = 34'(p01_reg); end
            4'd8: begin ma = 33'(k1_reg); mb = 34'(p00_reg); end
            4'd9: begin ma = 33'(k1_reg); mb = 34'(p01_reg); end
            default: mb = '0;
        endcase
    end

    kabf_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(ma), .b(mb),
        .done(mul_done), .prod_rnd(mrnd)
    );

    logic               div_start, div_done;
    logic signed [31:0] div_num, quo;
    assign div_num = step_reg[0] ? p10_reg : p00_reg;

    kabf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num_p(div_num),
        .den(s_reg), .done(div_done), .quo(quo)
    );

    assign mul_start = (state_reg == ST_MUL);
    assign div_start = (state_reg == ST_DIV);
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign m_tdata   = {orate_reg, oang_reg};

    logic signed [65:0] s_full;
    assign s_full = 66'(p00_reg) + 66'($signed({1'b0, r_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            qa_reg    <= RESET_Q_ANGLE;
            qb_reg    <= RESET_Q_BIAS;
            r_reg     <= RESET_R_MEAS;
            for (int i = 0; i < CHANNELS; i++)
            begin
                ang_mem[i]  <= '0;
                bias_mem[i] <= '0;
                p00_mem[i]  <= '0;
                p01_mem[i]  <= '0;
                p10_mem[i]  <= '0;
                p11_mem[i]  <= '0;
                rate_mem[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_Q_ANGLE: qa_reg <= cfg_data;
                    REG_Q_BIAS:  qb_reg <= cfg_data;
                    REG_R_MEAS:  r_reg  <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        act_reg  <= s_tuser;
                        ch_reg   <= s_tdata[1:0];
                        meas_reg <= s_tdata[33:2];
                        dt_reg   <= s_tdata[89:66];
                        step_reg <= '0;
                        if (bad_ch)
                        begin
                            oang_reg  <= '0;
                            orate_reg <= '0;
                            state_reg <= ST_OUT;
                        end
                        else if (s_tuser == ACT_SET)
                        begin
                            ang_mem[s_tdata[1:0]] <= s_tdata[33:2];
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            rate_reg <= sat32(66'($signed(s_tdata[65:34]))
                                              - 66'(bias_mem[s_tdata[1:0]]));
                            ang_reg  <= ang_mem[s_tdata[1:0]];
                            p00_reg  <= p00_mem[s_tdata[1:0]];
                            p01_reg  <= p01_mem[s_tdata[1:0]];
                            p10_reg  <= p10_mem[s_tdata[1:0]];
                            p11_reg  <= p11_mem[s_tdata[1:0]];
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                    state_reg <= ST_MWT;
                ST_MWT:
                begin
                    if (mul_done)
                    begin
                        state_reg <= ST_MUL;
                        step_reg  <= step_reg + 4'd1;
                        case (step_reg)
                            4'd0:
                            begin
                                rate_mem[ch_reg] <= rate_reg;
                                ang_reg <= sat32(66'(ang_reg) + mrnd);
                            end
                            4'd1:
                            begin
                                t_reg <= mrnd;
                                inner_reg <= mrnd - 66'(p01_reg) - 66'(p10_reg)
                                             + 66'($signed({1'b0, qa_reg}));
                            end
                            4'd2:
                            begin
                                // inner always fits in 34 bits
                                p00_reg <= sat32(66'(p00_reg) + mrnd);
                                p01_reg <= sat32(66'(p01_reg) - t_reg);
                                p10_reg <= sat32(66'(p10_reg) - t_reg);
                            end
                            4'd3:
                            begin
                                p11_reg <= sat32(66'(p11_reg) + mrnd);
                                state_reg <= ST_CALC;
                            end
                            4'd4: oang_reg <= sat32(66'(ang_reg) + mrnd);
                            4'd5: bias_mem[ch_reg] <= sat32(66'(bias_mem[ch_reg]) + mrnd);
                            4'd6: p00_mem[ch_reg] <= sat32(66'(p00_reg) - mrnd);
                            4'd7: p01_mem[ch_reg] <= sat32(66'(p01_reg) - mrnd);
                            4'd8: p10_mem[ch_reg] <= sat32(66'(p10_reg) - mrnd);
                            4'd9:
                            begin
                                p11_mem[ch_reg] <= sat32(66'(p11_reg) - mrnd);
                                state_reg <= ST_DONE;
                            end
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_CALC:
                begin
                    y_reg <= sat32(66'(meas_reg) - 66'(ang_reg));
                    s_reg <= s_full[32:0];
                    step_reg <= 4'd0;
                    if (s_full > 66'sd0)
                        state_reg <= ST_DIV;
                    else
                    begin
                        k0_reg <= '0;
                        k1_reg <= '0;
                        step_reg <= 4'd4;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIV:
                    state_reg <= ST_DWT;
                ST_DWT:
                begin
                    if (div_done)
                    begin
                        if (!step_reg[0])
                        begin
                            k0_reg <= quo;
                            step_reg <= 4'd1;
                            state_reg <= ST_DIV;
                        end
                        else
                        begin
                            k1_reg <= quo;
                            step_reg <= 4'd4;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (act_reg == ACT_SET)
                        oang_reg <= ang_mem[ch_reg];
                    else
                        ang_mem[ch_reg] <= oang_reg;
                    orate_reg <= rate_mem[ch_reg];
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
`endif

endmodule

/* sv/kabf_mul.sv */
// kabf_mul: shared signed multiplier, 33x34 split into two 33x17/33x18 halves,
// low half first; depends on kabf_pkg

module kabf_mul
    import kabf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [32:0]  a,
    input  logic signed [33:0]  b,
    output logic                done,
    output logic signed [65:0]  prod_rnd
);

    logic [1:0]          phase_reg;
    logic signed [32:0]  a_reg;
    logic signed [33:0]  b_reg;
    logic signed [65:0]  acc_reg;
    logic signed [50:0]  pp;
    logic                lo_phase;

    assign lo_phase = phase_reg[0];
    // low half unsigned 16 bits, high half signed 18 bits
    assign pp = lo_phase ? a_reg * $signed({1'b0, b_reg[15:0]})
                         : a_reg * $signed(b_reg[33:16]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
        end
        else
        begin
            if (start)
                phase_reg <= 2'd1;
            else if (phase_reg == 2'd1)
                phase_reg <= 2'd2;
            else
                phase_reg <= 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        if (phase_reg == 2'd1)
            acc_reg <= 66'(pp);
        else if (phase_reg == 2'd2)
            acc_reg <= acc_reg + (66'(pp) <<< 16);
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (phase_reg == 2'd2);
    end

    assign done     = done_reg;
    assign prod_rnd = rnd24(acc_reg);

endmodule

/* sv/kabf_div.sv */
// kabf_div: restoring signed divider, 56-bit dividend by 33-bit divisor,
// one quotient bit per cycle, truncating; depends on kabf_pkg

module kabf_div
    import kabf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [31:0]  num_p,     // numerator is num_p * 2^24
    input  logic [32:0]         den,       // positive divisor
    output logic                done,
    output logic signed [31:0]  quo
);

    localparam int NW = 56;

    logic [5:0]      cnt_reg;
    logic            busy_reg;
    logic            neg_reg;
    logic [NW-1:0]   q_reg;
    logic [33:0]     r_reg;
    logic [32:0]     d_reg;
    logic            done_reg;
    logic [33:0]     r_sh;
    logic [33:0]     r_sub;

    assign r_sh  = {r_reg[32:0], q_reg[NW-1]};
    assign r_sub = r_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(NW - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num_p[31];
            q_reg   <= {(num_p[31] ? 32'(-num_p) : 32'(num_p)), 24'd0};
            r_reg   <= '0;
            d_reg   <= den;
        end
        else if (busy_reg)
        begin
            if (!r_sub[33])
            begin
                r_reg <= r_sub;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    logic signed [65:0] qs;
    assign qs = neg_reg ? -$signed({10'd0, q_reg}) : $signed({10'd0, q_reg});
    assign done = done_reg;
    assign quo  = sat32(qs);

endmodule

/* tb/tb_kalman_angle_bias_filter.sv */
// tb_kalman_angle_bias_filter: self-checking testbench for the kalman angle/bias filter
// predicts each result with its own fixed-point filter model and checks the output stream
// depends on kabf_pkg and kalman_angle_bias_filter
`timescale 1ns / 100ps

module tb_kalman_angle_bias_filter;
    import kabf_pkg::*;

    typedef struct packed {
        logic signed [31:0] angle;
        logic signed [31:0] rate;
    } kf_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // channel[1:0], measured_angle, gyro_rate, time_step[23:0]
    logic         s_tuser;   // action
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // filtered_angle, unbiased_rate
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_data;

    // filter state mirror
    logic [30:0]        q_angle, q_bias, r_meas;
    logic signed [31:0] est_angle [4];
    logic signed [31:0] est_bias [4];
    logic signed [31:0] p_aa [4];
    logic signed [31:0] p_ab [4];
    logic signed [31:0] p_ba [4];
    logic signed [31:0] p_bb [4];
    logic signed [31:0] prev_rate [4];

    kf_result_t expected_results [$];
    int  error_count;
    bit  hold_off;
    int  long_stall;

    kalman_angle_bias_filter i_dut (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic signed [31:0] clamp32(input logic signed [127:0] x);
        if (x > 128'sd2147483647)
            return 32'sh7fffffff;
        if (x < -128'sd2147483648)
            return 32'sh80000000;
        return 32'(x);
    endfunction

    // round to nearest, ties up, then drop 24 fraction bits
    function automatic logic signed [127:0] round_frac(input logic signed [127:0] x);
        logic signed [127:0] t;
        t = x + 128'sd8388608;
        return t >>> 24;
    endfunction

    function automatic logic signed [31:0] kalman_gain(input logic signed [31:0] p,
                                                       input logic signed [127:0] s);
        logic signed [127:0] num;
        num = 128'(p) <<< 24;
        return clamp32(num / s);
    endfunction

    function automatic void reset_filter_model();
        q_angle = RESET_Q_ANGLE;
        q_bias  = RESET_Q_BIAS;
        r_meas  = RESET_R_MEAS;
        for (int i = 0; i < 4; i++)
        begin
            est_angle[i] = 0; est_bias[i] = 0; p_aa[i] = 0; p_ab[i] = 0;
            p_ba[i] = 0; p_bb[i] = 0; prev_rate[i] = 0;
        end
    endfunction

    function automatic kf_result_t predict_filter(input logic act, input logic [1:0] ch,
        input logic signed [31:0] meas, input logic signed [31:0] gyro,
        input logic [23:0] dt);
        kf_result_t r;
        logic signed [127:0] t, inner, s, dts;
        logic signed [31:0] rate, ang, p00, p01, p10, p11, k0, k1, y;
        dts = 128'(dt);
        if (ch >= CHANNELS)
        begin
            r.angle = 0; r.rate = 0;
            return r;
        end
        if (act == ACT_SET)
            est_angle[ch] = meas;
        else
        begin
            rate = clamp32(128'(gyro) - 128'(est_bias[ch]));
            prev_rate[ch] = rate;
            ang = clamp32(128'(est_angle[ch]) + round_frac(dts * 128'(rate)));
            p01 = p_ab[ch]; p10 = p_ba[ch]; p11 = p_bb[ch];
            t = round_frac(dts * 128'(p11));
            inner = t - 128'(p01) - 128'(p10) + 128'(q_angle);
            p00 = clamp32(128'(p_aa[ch]) + round_frac(dts * inner));
            p01 = clamp32(128'(p01) - t);
            p10 = clamp32(128'(p10) - t);
            p11 = clamp32(128'(p11) + round_frac(128'(q_bias) * dts));
            s = 128'(p00) + 128'(r_meas);
            if (s > 0)
            begin
                k0 = kalman_gain(p00, s);
                k1 = kalman_gain(p10, s);
            end
            else
            begin
                k0 = 0; k1 = 0;
            end
            y = clamp32(128'(meas) - 128'(ang));
            est_angle[ch] = clamp32(128'(ang) + round_frac(128'(k0) * 128'(y)));
            est_bias[ch] = clamp32(128'(est_bias[ch]) + round_frac(128'(k1) * 128'(y)));
            p_aa[ch] = clamp32(128'(p00) - round_frac(128'(k0) * 128'(p00)));
            p_ab[ch] = clamp32(128'(p01) - round_frac(128'(k0) * 128'(p01)));
            p_ba[ch] = clamp32(128'(p10) - round_frac(128'(k1) * 128'(p00)));
            p_bb[ch] = clamp32(128'(p11) - round_frac(128'(k1) * 128'(p01)));
        end
        r.angle = est_angle[ch];
        r.rate  = prev_rate[ch];
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(9) < 6)
            return 0;
        if ($urandom_range(9) < 8)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    task automatic send_item(input logic act, input logic [1:0] ch,
        input logic signed [31:0] meas, input logic signed [31:0] gyro,
        input logic [23:0] dt);
        int gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        // fields low to high: channel, measured_angle, gyro_rate, time_step
        s_tdata  <= 96'({dt, gyro, meas, ch});
        expected_results.push_back(predict_filter(act, ch, meas, gyro, dt));
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_Q_ANGLE: q_angle = val;
            REG_Q_BIAS:  q_bias  = val;
            REG_R_MEAS:  r_meas  = val;
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'sh7fffffff - $urandom_range(3);
            2: return 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom_range(180 << 16)) - (90 << 16);
        endcase
    endfunction

    function automatic logic [23:0] rand_dt();
        case ($urandom_range(5))
            0: return 24'($urandom());
            1: return 24'hffffff - 24'($urandom_range(3));
            default: return 24'($urandom_range(200000));
        endcase
    endfunction

    task automatic test_directed();
        send_item(ACT_UPDATE, 0, 0, 0, 0);
        send_item(ACT_SET, 0, 32'sh7fffffff, 0, 0);
        send_item(ACT_UPDATE, 0, 32'sh80000000, 32'sh7fffffff, 24'hffffff);
        send_item(ACT_UPDATE, 0, 32'sh7fffffff, 32'sh80000000, 24'hffffff);
        send_item(ACT_SET, 1, 32'sh80000000, 32'sh7fffffff, 24'hffffff);
        send_item(ACT_UPDATE, 1, 32'sh7fffffff, 32'sh80000000, 24'hffffff);
        send_item(ACT_UPDATE, 2, 5 << 16, 1 << 16, 167772);
        send_item(ACT_UPDATE, 2, -(5 << 16), -(1 << 16), 167772);
        // out-of-range channel changes nothing and returns zero
        send_item(ACT_UPDATE, 3, 32'sh12345678, 32'sh7654321, 24'h123456);
        send_item(ACT_SET, 3, 32'shffffffff, 32'shffffffff, 24'hffffff);
        send_item(ACT_SET, 2, 32'shdeadbeef, 0, 0);
        send_item(ACT_UPDATE, 2, 32'sh21524110, 32'sh5a5a5a5a, 24'ha5a5a5);
    endtask

    task automatic test_noise_settings();
        // large measurement and process noise first, then minimal noise settings
        write_reg(REG_R_MEAS, 31'h7fffffff);
        write_reg(REG_Q_ANGLE, 31'h7fffffff);
        write_reg(REG_Q_BIAS, 31'h7fffffff);
        for (int i = 0; i < 8; i++)
            send_item(ACT_UPDATE, 2'(i % 3), rand_angle(), rand_angle(), 24'hffffff);
        write_reg(REG_R_MEAS, 31'd1);
        write_reg(REG_Q_ANGLE, 31'd0);
        write_reg(REG_Q_BIAS, 31'd0);
        for (int i = 0; i < 8; i++)
            send_item(ACT_UPDATE, 2'(i % 3), rand_angle(), rand_angle(), rand_dt());
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_item($urandom_range(9) == 0, ($urandom_range(19) == 0) ? 2'd3
                      : 2'($urandom_range(2)), rand_angle(), rand_angle(), rand_dt());
    endtask

    task automatic test_backpressure();
        long_stall = 300;
        hold_off = 1'b1;
        for (int i = 0; i < 6; i++)
            send_item(ACT_UPDATE, 2'(i % 3), rand_angle(), rand_angle(), rand_dt());
    endtask

    // result checker
    always @(posedge clk)
    begin
        kf_result_t exp_r;
        if (m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no expectation: %h", m_tdata);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tdata[31:0] !== exp_r.angle)
                begin
                    $error("filtered_angle: expected %0d, got %0d", exp_r.angle,
                           $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tdata[63:32] !== exp_r.rate)
                begin
                    $error("unbiased_rate: expected %0d, got %0d", exp_r.rate,
                           $signed(m_tdata[63:32]));
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        hold_off = 1'b0;
        long_stall = 0;
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0; m_tready = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_Q_ANGLE; cfg_data = '0;
        reset_filter_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(500);
        test_noise_settings();
        write_reg(REG_Q_ANGLE, RESET_Q_ANGLE);
        write_reg(REG_Q_BIAS, 31'd90000);
        write_reg(REG_R_MEAS, 31'd40000);
        test_random(550);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random readiness with one long hold-off on request
    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (long_stall) @(posedge clk);
                hold_off = 1'b0;
                m_tready <= 1'b1;
            end
            else if (m_tready && m_tvalid)
            begin
                gap = pick_gap();
                if (gap != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

endmodule

/* files.f */
sv/kabf_pkg.sv
sv/kabf_mul.sv
sv/kabf_div.sv
sv/kalman_angle_bias_filter.sv
tb/tb_kalman_angle_bias_filter.sv
